FILE: hdl/mfd_pkg.sv
`default_nettype none

package mfd_pkg;

   // Configuration port geometry.
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 24;

   // Default number of fraction bits on the fixed point outputs.
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ANGLE_PER_COUNT   = 3'd0,
      CSR_SPEED_SMOOTHING   = 3'd1,
      CSR_CURRENT_SMOOTHING = 3'd2,
      CSR_DEG_TO_RAD_SCALE  = 3'd3,
      CSR_WRAP_THRESHOLD    = 3'd4
   } csr_index_type;

   // Register values after reset.
   localparam logic [23:0] ANGLE_PER_COUNT_RESET   = 24'd92160;
   localparam logic [16:0] SPEED_SMOOTHING_RESET   = 17'd65536;
   localparam logic [16:0] CURRENT_SMOOTHING_RESET = 17'd65536;
   localparam logic [23:0] DEG_TO_RAD_SCALE_RESET  = 24'd292818;
   localparam logic [15:0] WRAP_THRESHOLD_RESET    = 16'd8191;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_DIFF,
      ST_PRODUCT,
      ST_ACCUMULATE,
      ST_PUBLISH
   } state_type;

   // Step strobes from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic sample;
      logic diff;
      logic product;
      logic accumulate;
      logic publish;
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: hdl/motor_feedback_multiturn_decoder_core.sv
`default_nettype none
//
// Channel    Direction  Handshake                 Word
// req_       in         req_valid / req_ready     one 8-byte feedback frame
// rsp_       out        rsp_valid / rsp_ready     decoded fields, filtered values, turns
// csr_       in         csr_write_en, no wait     one register, index 0 to 4
//
// The frame is captured at the edge that accepts it; the sample, difference, product
// and accumulate steps then follow in turn, and publish loads the result register,
// from which the result word is offered once publish has loaded it.
// One frame is in work at a time; the next is taken only once the last is published.
// Reset clears the sequencer, the result flag, the turn counter, the filters and the
// previous encoder count, and loads the register defaults.
// A result left waiting on rsp_ready stalls only the publish step of the next frame.
//
module motor_feedback_multiturn_decoder_core #(
   parameter int unsigned FRACTION_BITS = mfd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [63:0]                          req_frame_bytes,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [7:0]                                rsp_command_echo,
   output logic [7:0]                                rsp_temperature,
   output logic [15:0]                               rsp_encoder_count,
   output logic [31:0]                               rsp_single_turn_angle,
   output logic signed [31:0]                        rsp_speed_filtered,
   output logic signed [31:0]                        rsp_current_filtered,
   output logic signed [31:0]                        rsp_turn_total,
   output logic signed [63:0]                        rsp_multiturn_angle,
   input  wire logic                                 csr_write_en,
   input  wire logic [mfd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mfd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import mfd_pkg::*;

   dp_cmd_type cmd;

   // Sequencer.
   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic, state and configuration registers.
   mfd_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_frame_bytes       (req_frame_bytes),
      .rsp_command_echo      (rsp_command_echo),
      .rsp_temperature       (rsp_temperature),
      .rsp_encoder_count     (rsp_encoder_count),
      .rsp_single_turn_angle (rsp_single_turn_angle),
      .rsp_speed_filtered    (rsp_speed_filtered),
      .rsp_current_filtered  (rsp_current_filtered),
      .rsp_turn_total        (rsp_turn_total),
      .rsp_multiturn_angle   (rsp_multiturn_angle)
   );

endmodule

`default_nettype wire

FILE: hdl/mfd_ctrl.sv
`default_nettype none

module mfd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output mfd_pkg::dp_cmd_type     cmd
);
   import mfd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   // The output register may be reloaded once its word has gone or is going now.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SAMPLE;
         end
         ST_SAMPLE:     state_in = ST_DIFF;
         ST_DIFF:       state_in = ST_PRODUCT;
         ST_PRODUCT:    state_in = ST_ACCUMULATE;
         ST_ACCUMULATE: state_in = ST_PUBLISH;
         ST_PUBLISH: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs and step strobes.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SAMPLE:     cmd.sample     = 1'b1;
         ST_DIFF:       cmd.diff       = 1'b1;
         ST_PRODUCT:    cmd.product    = 1'b1;
         ST_ACCUMULATE: cmd.accumulate = 1'b1;
         ST_PUBLISH:    cmd.publish    = slot_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Result valid flag: set on publish, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/mfd_datapath.sv
`default_nettype none

module mfd_datapath #(
   parameter int unsigned FRACTION_BITS = mfd_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mfd_pkg::dp_cmd_type                  cmd,
   input  wire logic                                 csr_write_en,
   input  wire logic [mfd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mfd_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  wire logic [63:0]                          req_frame_bytes,
   output logic [7:0]                                rsp_command_echo,
   output logic [7:0]                                rsp_temperature,
   output logic [15:0]                               rsp_encoder_count,
   output logic [31:0]                               rsp_single_turn_angle,
   output logic signed [31:0]                        rsp_speed_filtered,
   output logic signed [31:0]                        rsp_current_filtered,
   output logic signed [31:0]                        rsp_turn_total,
   output logic signed [63:0]                        rsp_multiturn_angle
);
   import mfd_pkg::*;

   localparam int unsigned         SCALE_SHIFT  = 24 - FRACTION_BITS;
   localparam int unsigned         WEIGHT_SHIFT = 16;
   localparam logic [16:0]         WEIGHT_ONE   = 17'h1_0000;
   localparam logic signed [31:0]  INT32_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0]  INT32_MIN    = 32'sh8000_0000;
   localparam logic signed [63:0]  INT64_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0]  INT64_MIN    = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0]  TURN_LIMIT   = INT64_MAX >>> FRACTION_BITS;
   localparam logic signed [40:0]  DEG_PER_TURN = 41'sd360;

   // Clamp a wide signed value into the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] value);
      logic signed [31:0] result;
      if (value[63:31] == {33{value[63]}}) begin
         result = value[31:0];
      end else if (value[63]) begin
         result = INT32_MIN;
      end else begin
         result = INT32_MAX;
      end
      return result;
   endfunction

   // Configuration registers.
   logic [23:0] angle_per_count_ff;
   logic [16:0] speed_smoothing_ff;
   logic [16:0] current_smoothing_ff;
   logic [23:0] deg_to_rad_ff;
   logic [15:0] wrap_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_per_count_ff   <= ANGLE_PER_COUNT_RESET;
         speed_smoothing_ff   <= SPEED_SMOOTHING_RESET;
         current_smoothing_ff <= CURRENT_SMOOTHING_RESET;
         deg_to_rad_ff        <= DEG_TO_RAD_SCALE_RESET;
         wrap_threshold_ff    <= WRAP_THRESHOLD_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ANGLE_PER_COUNT:   angle_per_count_ff   <= csr_wdata;
            CSR_SPEED_SMOOTHING:   speed_smoothing_ff   <= csr_wdata[16:0];
            CSR_CURRENT_SMOOTHING: current_smoothing_ff <= csr_wdata[16:0];
            CSR_DEG_TO_RAD_SCALE:  deg_to_rad_ff        <= csr_wdata;
            CSR_WRAP_THRESHOLD:    wrap_threshold_ff    <= csr_wdata[15:0];
            default: begin
               angle_per_count_ff <= angle_per_count_ff;
            end
         endcase
      end
   end

   // Captured frame.
   logic [63:0] frame_ff;
   logic [15:0] enc;
   logic [15:0] cur_raw;
   logic [15:0] spd_raw;

   always_ff @(posedge clock) begin
      if (cmd.capture) frame_ff <= req_frame_bytes;
   end

   assign cur_raw = frame_ff[31:16];
   assign spd_raw = frame_ff[47:32];
   assign enc     = frame_ff[63:48];

   // Sample step: single-turn angle, speed and current samples, turn detection.
   logic [39:0]        single_prod;
   logic [39:0]        single_shift;
   logic [31:0]        single_in;
   logic [31:0]        single_ff;
   logic signed [40:0] spd_prod;
   logic signed [40:0] cur_wide;
   logic signed [31:0] spd_sample_in;
   logic signed [31:0] spd_sample_ff;
   logic signed [31:0] cur_sample_in;
   logic signed [31:0] cur_sample_ff;
   logic signed [17:0] enc_step;
   logic signed [17:0] thr_pos;
   logic               turn_dec;
   logic               turn_inc;
   logic signed [31:0] turn_in;
   logic signed [31:0] turn_ff;
   logic [15:0]        enc_prev_ff;

   assign single_prod   = {24'd0, enc} * {16'd0, angle_per_count_ff};
   assign single_shift  = single_prod >> SCALE_SHIFT;
   assign single_in     = (|single_shift[39:32]) ? 32'hFFFF_FFFF : single_shift[31:0];

   assign spd_prod      = $signed({{25{spd_raw[15]}}, spd_raw}) * $signed({17'd0, deg_to_rad_ff});
   assign spd_sample_in = sat32(64'(spd_prod >>> SCALE_SHIFT));

   assign cur_wide      = $signed({{25{cur_raw[15]}}, cur_raw}) <<< FRACTION_BITS;
   assign cur_sample_in = sat32(64'(cur_wide));

   assign enc_step = $signed({2'b00, enc}) - $signed({2'b00, enc_prev_ff});
   assign thr_pos  = $signed({2'b00, wrap_threshold_ff});
   assign turn_dec = enc_step > thr_pos;
   assign turn_inc = enc_step < -thr_pos;

   // A large forward step means the encoder wrapped backwards, and the reverse.
   always_comb begin
      turn_in = turn_ff;
      if (turn_dec) begin
         if (turn_ff != INT32_MIN) turn_in = turn_ff - 32'sd1;
      end else if (turn_inc) begin
         if (turn_ff != INT32_MAX) turn_in = turn_ff + 32'sd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff     <= '0;
         enc_prev_ff <= '0;
      end else if (cmd.sample) begin
         turn_ff     <= turn_in;
         enc_prev_ff <= enc;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample) begin
         single_ff     <= single_in;
         spd_sample_ff <= spd_sample_in;
         cur_sample_ff <= cur_sample_in;
      end
   end

   // Difference step: sample minus accumulator, clamped weights, turns in degrees.
   logic signed [31:0] spd_acc_ff;
   logic signed [31:0] cur_acc_ff;
   logic signed [32:0] spd_diff_in;
   logic signed [32:0] spd_diff_ff;
   logic signed [32:0] cur_diff_in;
   logic signed [32:0] cur_diff_ff;
   logic [16:0]        spd_weight_in;
   logic [16:0]        spd_weight_ff;
   logic [16:0]        cur_weight_in;
   logic [16:0]        cur_weight_ff;
   logic signed [40:0] turns360_in;
   logic signed [40:0] turns360_ff;

   assign spd_diff_in   = 33'(spd_sample_ff) - 33'(spd_acc_ff);
   assign cur_diff_in   = 33'(cur_sample_ff) - 33'(cur_acc_ff);
   assign spd_weight_in = speed_smoothing_ff[16] ? WEIGHT_ONE : speed_smoothing_ff;
   assign cur_weight_in = current_smoothing_ff[16] ? WEIGHT_ONE : current_smoothing_ff;
   assign turns360_in   = 41'(turn_ff) * DEG_PER_TURN;

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         spd_diff_ff   <= spd_diff_in;
         cur_diff_ff   <= cur_diff_in;
         spd_weight_ff <= spd_weight_in;
         cur_weight_ff <= cur_weight_in;
         turns360_ff   <= turns360_in;
      end
   end

   // Product step: weighted differences and the saturated total angle.
   logic signed [49:0] spd_wprod_in;
   logic signed [49:0] spd_wprod_ff;
   logic signed [49:0] cur_wprod_in;
   logic signed [49:0] cur_wprod_ff;
   logic signed [63:0] turns_wide;
   logic signed [63:0] turns_scaled;
   logic signed [64:0] total_sum;
   logic signed [63:0] total_in;
   logic signed [63:0] total_ff;

   assign spd_wprod_in = 50'(spd_diff_ff) * $signed({33'd0, spd_weight_ff});
   assign cur_wprod_in = 50'(cur_diff_ff) * $signed({33'd0, cur_weight_ff});

   assign turns_wide   = 64'(turns360_ff);
   assign turns_scaled = turns_wide <<< FRACTION_BITS;
   assign total_sum    = 65'(turns_scaled) + $signed({33'd0, single_ff});

   // Whole turns beyond the 64-bit range pin the total; the sum can only overflow upwards.
   always_comb begin
      if (turns_wide > TURN_LIMIT) begin
         total_in = INT64_MAX;
      end else if (turns_wide < -TURN_LIMIT) begin
         total_in = INT64_MIN;
      end else if (total_sum[64] != total_sum[63]) begin
         total_in = INT64_MAX;
      end else begin
         total_in = total_sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.product) begin
         spd_wprod_ff <= spd_wprod_in;
         cur_wprod_ff <= cur_wprod_in;
         total_ff     <= total_in;
      end
   end

   // Accumulate step: exponential smoothing with floor on the weight shift.
   logic signed [31:0] spd_acc_in;
   logic signed [31:0] cur_acc_in;

   assign spd_acc_in = sat32(64'(35'(spd_acc_ff) + 35'(spd_wprod_ff >>> WEIGHT_SHIFT)));
   assign cur_acc_in = sat32(64'(35'(cur_acc_ff) + 35'(cur_wprod_ff >>> WEIGHT_SHIFT)));

   always_ff @(posedge clock) begin
      if (reset) begin
         spd_acc_ff <= '0;
         cur_acc_ff <= '0;
      end else if (cmd.accumulate) begin
         spd_acc_ff <= spd_acc_in;
         cur_acc_ff <= cur_acc_in;
      end
   end

   // Output word register.
   logic [7:0]         out_cmd_ff;
   logic [7:0]         out_temp_ff;
   logic [15:0]        out_enc_ff;
   logic [31:0]        out_single_ff;
   logic signed [31:0] out_speed_ff;
   logic signed [31:0] out_current_ff;
   logic signed [31:0] out_turn_ff;
   logic signed [63:0] out_total_ff;

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         out_cmd_ff     <= frame_ff[7:0];
         out_temp_ff    <= frame_ff[15:8];
         out_enc_ff     <= enc;
         out_single_ff  <= single_ff;
         out_speed_ff   <= spd_acc_ff;
         out_current_ff <= cur_acc_ff;
         out_turn_ff    <= turn_ff;
         out_total_ff   <= total_ff;
      end
   end

   assign rsp_command_echo      = out_cmd_ff;
   assign rsp_temperature       = out_temp_ff;
   assign rsp_encoder_count     = out_enc_ff;
   assign rsp_single_turn_angle = out_single_ff;
   assign rsp_speed_filtered    = out_speed_ff;
   assign rsp_current_filtered  = out_current_ff;
   assign rsp_turn_total        = out_turn_ff;
   assign rsp_multiturn_angle   = out_total_ff;

endmodule

`default_nettype wire

FILE: hdl/mfd_checker.sv
`default_nettype none

module mfd_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_turn_total,
   input wire logic signed [63:0] rsp_multiturn_angle
);

   // A word on offer stays on offer until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // A stalled word keeps its total angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_multiturn_angle))
      else $error("total angle changed while the result word was stalled");

   // No result is on offer in the first cycle after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word present straight after reset");

   // A frame just taken keeps the input closed and produces no result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !$rose(rsp_valid))
      else $error("frame sequencing broken after acceptance");

   // A non-negative turn count never gives a negative total angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_turn_total[31] |-> !rsp_multiturn_angle[63])
      else $error("total angle sign disagrees with the turn count");

endmodule

bind motor_feedback_multiturn_decoder_core mfd_checker u_mfd_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mfd_pkg::*;

   localparam int unsigned FB = FRACTION_BITS_DEFAULT;
   localparam int unsigned PRODUCT_SHIFT = 24 - FB;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int unsigned GAP_PERCENT = 32;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam logic signed [31:0] NARROW_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] NARROW_MIN = 32'sh8000_0000;
   localparam longint WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint WIDE_MIN = 64'sh8000_0000_0000_0000;

   // One decoded feedback word as it leaves the block.
   typedef struct {
      logic [7:0]         command_echo;
      logic [7:0]         temperature;
      logic [15:0]        encoder_count;
      logic [31:0]        single_turn_angle;
      logic signed [31:0] speed_filtered;
      logic signed [31:0] current_filtered;
      logic signed [31:0] turn_total;
      logic signed [63:0] multiturn_angle;
   } feedback_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [63:0]                req_frame_bytes = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [7:0]                 rsp_command_echo;
   logic [7:0]                 rsp_temperature;
   logic [15:0]                rsp_encoder_count;
   logic [31:0]                rsp_single_turn_angle;
   logic signed [31:0]         rsp_speed_filtered;
   logic signed [31:0]         rsp_current_filtered;
   logic signed [31:0]         rsp_turn_total;
   logic signed [63:0]         rsp_multiturn_angle;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Register copies held by the predictor.
   logic [23:0] cfg_angle_per_count = ANGLE_PER_COUNT_RESET;
   logic [16:0] cfg_speed_weight    = SPEED_SMOOTHING_RESET;
   logic [16:0] cfg_current_weight  = CURRENT_SMOOTHING_RESET;
   logic [23:0] cfg_deg_to_rad      = DEG_TO_RAD_SCALE_RESET;
   logic [15:0] cfg_wrap_threshold  = WRAP_THRESHOLD_RESET;

   // Tracking state of the predictor, cleared like the block at reset.
   logic [15:0]        last_count = '0;
   logic signed [31:0] speed_level = '0;
   logic signed [31:0] current_level = '0;
   logic signed [31:0] turn_count = '0;

   logic [63:0]       frame_queue[$];
   feedback_word_type predicted_words[$];
   logic              frame_taken = 1'b0;
   logic              gaps_on = 1'b1;
   logic [15:0]       walk_count = '0;
   int unsigned       mismatch_count = 0;

   motor_feedback_multiturn_decoder_core #(
      .FRACTION_BITS(FB)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_frame_bytes       (req_frame_bytes),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_command_echo      (rsp_command_echo),
      .rsp_temperature       (rsp_temperature),
      .rsp_encoder_count     (rsp_encoder_count),
      .rsp_single_turn_angle (rsp_single_turn_angle),
      .rsp_speed_filtered    (rsp_speed_filtered),
      .rsp_current_filtered  (rsp_current_filtered),
      .rsp_turn_total        (rsp_turn_total),
      .rsp_multiturn_angle   (rsp_multiturn_angle),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic signed [31:0] clamp_to_int32(longint value);
      if (value > NARROW_MAX) return NARROW_MAX;
      if (value < NARROW_MIN) return NARROW_MIN;
      return value[31:0];
   endfunction

   // Exponential smoothing; a weight above one behaves as exactly one.
   function automatic logic signed [31:0] smooth_toward(logic signed [31:0] level,
         logic signed [31:0] sample, logic [16:0] weight);
      longint gain;
      longint gap;
      longint wide_level;
      gain = (weight > 17'd65536) ? 64'd65536 : {47'd0, weight};
      gap = longint'(sample);
      wide_level = longint'(level);
      gap = gap - wide_level;
      return clamp_to_int32(wide_level + ((gap * gain) >>> 16));
   endfunction

   // Decodes one frame and advances the filters and the turn counter.
   function automatic feedback_word_type decode_frame(logic [63:0] frame);
      feedback_word_type  word;
      logic [15:0]        count;
      logic signed [15:0] current_raw;
      logic signed [15:0] speed_raw;
      longint unsigned    angle_wide;
      longint             speed_sample;
      longint             current_wide;
      longint             step;
      longint             threshold;
      longint             turns_deg;
      longint             limit;
      longint             single_wide;
      longint             total;
      count = frame[63:48];
      speed_raw = frame[47:32];
      current_raw = frame[31:16];
      word.command_echo = frame[7:0];
      word.temperature = frame[15:8];
      word.encoder_count = count;

      // Single-turn angle, truncated and clamped to 32 bits.
      angle_wide = ({48'd0, count} * {40'd0, cfg_angle_per_count}) >> PRODUCT_SHIFT;
      word.single_turn_angle = (angle_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                            : angle_wide[31:0];

      // Speed to rad/s with a floor shift, current to fixed point, then smoothing.
      speed_sample = longint'(speed_raw);
      speed_sample = (speed_sample * longint'({40'd0, cfg_deg_to_rad})) >>> PRODUCT_SHIFT;
      current_wide = longint'(current_raw);
      speed_level = smooth_toward(speed_level, clamp_to_int32(speed_sample),
                                  cfg_speed_weight);
      current_level = smooth_toward(current_level, clamp_to_int32(current_wide <<< FB),
                                    cfg_current_weight);
      word.speed_filtered = speed_level;
      word.current_filtered = current_level;

      // A large forward step means the count wrapped backwards, and the reverse.
      step = longint'({48'd0, count}) - longint'({48'd0, last_count});
      threshold = longint'({48'd0, cfg_wrap_threshold});
      if (step > threshold) begin
         if (turn_count != NARROW_MIN) turn_count = turn_count - 1;
      end else if (step < -threshold) begin
         if (turn_count != NARROW_MAX) turn_count = turn_count + 1;
      end
      last_count = count;
      word.turn_total = turn_count;

      // Total angle with saturation to the 64-bit range.
      turns_deg = longint'(turn_count);
      turns_deg = turns_deg * 360;
      limit = WIDE_MAX >>> FB;
      single_wide = {32'd0, word.single_turn_angle};
      if (turns_deg > limit) begin
         total = WIDE_MAX;
      end else if (turns_deg < -limit) begin
         total = WIDE_MIN;
      end else begin
         total = turns_deg <<< FB;
         total = (total > WIDE_MAX - single_wide) ? WIDE_MAX : total + single_wide;
      end
      word.multiturn_angle = total;
      return word;
   endfunction

   function automatic logic [63:0] make_frame(logic [7:0] command, logic [7:0] temp,
         logic [15:0] current_raw, logic [15:0] speed_raw, logic [15:0] count);
      return {count, speed_raw, current_raw, temp, command};
   endfunction

   // Random frames follow a walking encoder, often stepping right at the threshold.
   function automatic logic [63:0] random_frame();
      logic [15:0] count;
      logic [15:0] offset;
      logic [15:0] current_raw;
      logic [15:0] speed_raw;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         offset = 16'($urandom_range(2000));
      end else if (pick < 80) begin
         offset = cfg_wrap_threshold + 16'($urandom_range(2)) - 16'd1;
      end else begin
         offset = 16'($urandom);
      end
      count = ($urandom_range(1) != 0) ? walk_count + offset : walk_count - offset;
      walk_count = count;
      current_raw = 16'($urandom);
      speed_raw = 16'($urandom);
      if ($urandom_range(9) == 0) current_raw = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
      if ($urandom_range(9) == 0) speed_raw = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
      return make_frame(8'($urandom), 8'($urandom), current_raw, speed_raw, count);
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Writes one register, with random bits above its width, and updates the copy.
   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] index, logic [23:0] value);
      logic [CSR_DATA_WIDTH-1:0] data;
      data = 24'($urandom);
      case (index)
         CSR_ANGLE_PER_COUNT: begin
            data = value;
            cfg_angle_per_count = value;
         end
         CSR_SPEED_SMOOTHING: begin
            data[16:0] = value[16:0];
            cfg_speed_weight = value[16:0];
         end
         CSR_CURRENT_SMOOTHING: begin
            data[16:0] = value[16:0];
            cfg_current_weight = value[16:0];
         end
         CSR_DEG_TO_RAD_SCALE: begin
            data = value;
            cfg_deg_to_rad = value;
         end
         CSR_WRAP_THRESHOLD: begin
            data[15:0] = value[15:0];
            cfg_wrap_threshold = value[15:0];
         end
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
   endtask

   task automatic set_config(logic [23:0] angle, logic [16:0] speed_weight,
         logic [16:0] current_weight, logic [23:0] to_rad, logic [15:0] threshold);
      write_register(CSR_ANGLE_PER_COUNT, angle);
      write_register(CSR_SPEED_SMOOTHING, 24'(speed_weight));
      write_register(CSR_CURRENT_SMOOTHING, 24'(current_weight));
      write_register(CSR_DEG_TO_RAD_SCALE, to_rad);
      write_register(CSR_WRAP_THRESHOLD, 24'(threshold));
      // A write to an unused index must leave every register alone.
      write_register(CSR_UNUSED_INDEX, 24'($urandom));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every frame has been taken and every decoded word has returned.
   task automatic wait_drained();
      while (frame_queue.size() != 0 || req_valid || predicted_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random(int unsigned amount);
      repeat (amount) frame_queue.push_back(random_frame());
   endtask

   // Request driver: a new word goes out once the previous one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || frame_taken) begin
         frame_taken = 1'b0;
         if (frame_queue.size() != 0 && !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
            req_valid <= 1'b1;
            req_frame_bytes <= frame_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // The receiving side stalls at random.
   always @(negedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
   end

   // Monitor: checks each returned word, then predicts the word for a frame just taken.
   always @(posedge clock) begin
      feedback_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_words.size() == 0) begin
            $display("%0t ns: decoded word returned with none outstanding", $time);
            mismatch_count++;
         end else begin
            want = predicted_words.pop_front();
            check_field("command_echo", 64'(want.command_echo), 64'(rsp_command_echo));
            check_field("temperature", 64'(want.temperature), 64'(rsp_temperature));
            check_field("encoder_count", 64'(want.encoder_count), 64'(rsp_encoder_count));
            check_field("single_turn_angle", 64'(want.single_turn_angle),
                        64'(rsp_single_turn_angle));
            check_field("speed_filtered", 64'(want.speed_filtered),
                        64'(rsp_speed_filtered));
            check_field("current_filtered", 64'(want.current_filtered),
                        64'(rsp_current_filtered));
            check_field("turn_total", 64'(want.turn_total), 64'(rsp_turn_total));
            check_field("multiturn_angle", want.multiturn_angle, rsp_multiturn_angle);
         end
      end
      if (!reset && req_valid && req_ready) begin
         predicted_words.push_back(decode_frame(req_frame_bytes));
         frame_taken = 1'b1;
      end
   end

   // Stimulus: directed frames on the reset settings, then random phases.
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The first frame sits above the threshold, so it counts a turn down.
      frame_queue.push_back(make_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 16'd9000));
      frame_queue.push_back(make_frame(8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
      frame_queue.push_back(make_frame(8'h00, 8'h00, 16'h8000, 16'h8000, 16'h0000));
      // Steps exactly at the threshold do not count; one beyond it does.
      frame_queue.push_back(make_frame(8'h01, 8'h02, 16'h0001, 16'hFFFF, 16'd8191));
      frame_queue.push_back(make_frame(8'h80, 8'h40, 16'hFFFF, 16'h0001, 16'd0));
      frame_queue.push_back(make_frame(8'h7F, 8'hBF, 16'h1234, 16'hEDCB, 16'd8192));
      frame_queue.push_back(make_frame(8'hAA, 8'h55, 16'h8000, 16'h7FFF, 16'd0));
      frame_queue.push_back(make_frame(8'h55, 8'hAA, 16'h7FFF, 16'h8000, 16'h8000));
      frame_queue.push_back(make_frame(8'hC3, 8'h3C, 16'h0000, 16'h0000, 16'h7FFF));
      frame_queue.push_back(make_frame(8'h3C, 8'hC3, 16'h5A5A, 16'hA5A5, 16'hFFFF));
      frame_queue.push_back(make_frame(8'hFF, 8'h00, 16'hA5A5, 16'h5A5A, 16'h0000));
      queue_random(250);
      wait_drained();

      // Largest scales, a smoothing weight above one, a frozen current filter and
      // a zero threshold, so that every move counts.
      set_config(24'hFF_FFFF, 17'h1_FFFF, 17'd0, 24'hFF_FFFF, 16'd0);
      queue_random(260);
      wait_drained();

      // Zero scales, the smallest weight and a threshold no step can exceed.
      set_config(24'd0, 17'd1, 17'd65536, 24'd0, 16'hFFFF);
      queue_random(260);
      wait_drained();

      set_config(24'($urandom), 17'($urandom_range(65536)), 17'($urandom_range(65536)),
                 24'($urandom), 16'($urandom_range(12000)));
      queue_random(260);
      wait_drained();

      // Back to the reset values with both sides running flat out.
      gaps_on = 1'b0;
      set_config(ANGLE_PER_COUNT_RESET, SPEED_SMOOTHING_RESET, CURRENT_SMOOTHING_RESET,
                 DEG_TO_RAD_SCALE_RESET, WRAP_THRESHOLD_RESET);
      queue_random(260);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
